>>> rtl/ber_record_deframer_top_defines.svh
// Assertion macros for the record deframer checker.
// Used by ber_chk.sv; needs a clk and rst in scope at the point of use.
`ifndef BER_RECORD_DEFRAMER_TOP_DEFINES_SVH
`define BER_RECORD_DEFRAMER_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BER_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ber_record_deframer: check failed");

// Check cons in the cycle after ante.
`define BER_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ber_record_deframer: check failed");

`endif

>>> rtl/ber_pkg.sv
// Shared types and constants for the record deframer.
// No dependencies.
`timescale 1ns / 1ps

package ber_pkg;

  localparam int RECORDS = 4;
  localparam int SAMPLES = 64;

  localparam int WORD_W  = 32;
  localparam int ACT_W   = 3;
  localparam int RIDX_W  = 2;
  localparam int SIDX_W  = 6;
  localparam int STAT_W  = 2;

  localparam int REC_W   = (RECORDS > 1) ? $clog2(RECORDS) : 1;
  localparam int CNT_W   = $clog2(2 * SAMPLES + 1);

  localparam logic [WORD_W-1:0] SIGNATURE_WORD = 32'h4245_5253;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 3'd0,
    ACT_OPEN = 3'd1,
    ACT_MODE = 3'd2,
    ACT_TIME = 3'd3,
    ACT_ERR  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_RECORDS = 2'd1,
    ST_SAMPLES = 2'd2,
    ST_NOSIG   = 2'd3
  } status_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last_word;
  } in_item_t;

  typedef struct packed {
    action_t           action;
    logic [RIDX_W-1:0] record_index;
    logic [SIDX_W-1:0] sample_index;
    logic [WORD_W-1:0] value;
    status_t           status;
    logic              done_res;
  } res_t;

endpackage

>>> rtl/ber_in_reg.sv
// Input register stage of the record deframer.
// Depends on ber_pkg.
`timescale 1ns / 1ps

module ber_in_reg import ber_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_stall,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_stall,
  output in_item_t dn_item
);

  logic     valid_q;
  logic     valid_q_next;
  in_item_t item_q;
  logic     load;

  assign up_stall     = valid_q & dn_stall;
  assign load         = up_valid & ~up_stall;
  assign valid_q_next = load | (valid_q & dn_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_q <= up_item;
    end
  end

  assign dn_valid = valid_q;
  assign dn_item  = item_q;

endmodule

>>> rtl/ber_parse.sv
// Record parser: sticky state and per-word decode of the buffer.
// Depends on ber_pkg.
`timescale 1ns / 1ps

module ber_parse import ber_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_item_t item,
  output res_t     res
);

  logic             have_record;
  logic             have_record_next;
  logic [REC_W-1:0] current_record;
  logic [REC_W-1:0] current_record_next;
  logic             expect_mode;
  logic             expect_mode_next;
  logic [CNT_W-1:0] sample_count;
  logic [CNT_W-1:0] sample_count_next;
  status_t          failed_code;
  status_t          failed_code_next;
  logic [CNT_W-1:0] err_offset;

  assign err_offset = sample_count - CNT_W'(SAMPLES);

  always_comb begin
    have_record_next    = have_record;
    current_record_next = current_record;
    expect_mode_next    = expect_mode;
    sample_count_next   = sample_count;
    failed_code_next    = failed_code;
    res                 = '0;
    res.action          = ACT_NONE;

    if (failed_code == ST_OK) begin
      priority if (item.word == SIGNATURE_WORD) begin
        if (have_record && (current_record == REC_W'(RECORDS - 1))) begin
          failed_code_next = ST_RECORDS;
        end else begin
          current_record_next = have_record ? current_record + 1'b1 : '0;
          have_record_next    = 1'b1;
          expect_mode_next    = 1'b1;
          sample_count_next   = '0;
          res.action          = ACT_OPEN;
          res.record_index    = RIDX_W'(current_record_next);
        end
      end else if (!have_record) begin
        failed_code_next = ST_NOSIG;
      end else if (expect_mode) begin
        expect_mode_next = 1'b0;
        res.action       = ACT_MODE;
        res.record_index = RIDX_W'(current_record);
        res.value        = item.word;
      end else if (sample_count >= CNT_W'(2 * SAMPLES)) begin
        failed_code_next = ST_SAMPLES;
      end else begin
        res.record_index = RIDX_W'(current_record);
        res.value        = item.word;
        if (sample_count < CNT_W'(SAMPLES)) begin
          res.action       = ACT_TIME;
          res.sample_index = SIDX_W'(sample_count);
        end else begin
          res.action       = ACT_ERR;
          res.sample_index = SIDX_W'(err_offset);
        end
        sample_count_next = sample_count + 1'b1;
      end
    end

    res.status   = failed_code_next;
    res.done_res = item.last_word;

    if (item.last_word) begin
      have_record_next    = 1'b0;
      current_record_next = '0;
      expect_mode_next    = 1'b0;
      sample_count_next   = '0;
      failed_code_next    = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_record    <= 1'b0;
      current_record <= '0;
      expect_mode    <= 1'b0;
      sample_count   <= '0;
      failed_code    <= ST_OK;
    end else if (fire) begin
      have_record    <= have_record_next;
      current_record <= current_record_next;
      expect_mode    <= expect_mode_next;
      sample_count   <= sample_count_next;
      failed_code    <= failed_code_next;
    end
  end

endmodule

>>> rtl/ber_out_buf.sv
// Result register with skid entry; upstream stall is registered.
// Depends on ber_pkg.
`timescale 1ns / 1ps

module ber_out_buf import ber_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_stall,
  input  res_t up_res,
  output logic dn_valid,
  input  logic dn_stall,
  output res_t dn_res
);

  logic head_valid;
  logic skid_valid;
  res_t head;
  res_t skid;
  logic push;
  logic pop;

  assign up_stall = skid_valid;
  assign push     = up_valid & ~skid_valid;
  assign pop      = head_valid & ~dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop || !head_valid) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_valid) begin
      if (skid_valid) begin
        head <= skid;
      end else if (push) begin
        head <= up_res;
      end
    end else if (push) begin
      skid <= up_res;
    end
  end

  assign dn_valid = head_valid;
  assign dn_res   = head;

endmodule

>>> rtl/ber_record_deframer_top.sv
// Channel  | handshake          | payload
// input    | in_valid, in_stall | word, last_word
// result   | out_valid, out_stall | action, record_index, sample_index, value, status, done_res
//
// One word per cycle when out_stall is low; results are registered after the input register.
// Throughput is set by the single decode stage between the input and result registers.
// rst is synchronous: it clears the parser state and empties both registers.
// A stalled result is held in the result register and one more in the skid entry;
// in_stall rises only when both are full and a word waits in the input register.
// Top level of the record deframer; depends on ber_pkg, ber_in_reg, ber_parse, ber_out_buf.
`timescale 1ns / 1ps

module ber_record_deframer_top import ber_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] word,
  input  logic              last_word,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ACT_W-1:0]  action,
  output logic [RIDX_W-1:0] record_index,
  output logic [SIDX_W-1:0] sample_index,
  output logic [WORD_W-1:0] value,
  output logic [STAT_W-1:0] status,
  output logic              done_res
);

  in_item_t in_item;
  in_item_t reg_item;
  logic     reg_valid;
  logic     buf_stall;
  logic     fire;
  res_t     parse_res;
  res_t     out_res;

  assign in_item.word      = word;
  assign in_item.last_word = last_word;
  assign fire              = reg_valid & ~buf_stall;

  ber_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_stall (in_stall),
    .up_item  (in_item),
    .dn_valid (reg_valid),
    .dn_stall (buf_stall),
    .dn_item  (reg_item)
  );

  ber_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (reg_item),
    .res  (parse_res)
  );

  ber_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .up_valid (reg_valid),
    .up_stall (buf_stall),
    .up_res   (parse_res),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_res   (out_res)
  );

  assign action       = out_res.action;
  assign record_index = out_res.record_index;
  assign sample_index = out_res.sample_index;
  assign value        = out_res.value;
  assign status       = out_res.status;
  assign done_res     = out_res.done_res;

endmodule

>>> rtl/ber_chk.sv
// Port-level checks for the record deframer, bound to the top level.
// Depends on ber_pkg and ber_record_deframer_top_defines.svh.
`timescale 1ns / 1ps
`include "ber_record_deframer_top_defines.svh"

module ber_chk import ber_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input logic [ACT_W-1:0]  action,
  input logic [RIDX_W-1:0] record_index,
  input logic [SIDX_W-1:0] sample_index,
  input logic [WORD_W-1:0] value,
  input logic [STAT_W-1:0] status
);

  `BER_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(value) && $stable(action))
  `BER_ASSERT_NOW(a_err_no_action, out_valid && (status != ST_OK), action == ACT_NONE)
  `BER_ASSERT_NOW(a_none_zero, out_valid && (action == ACT_NONE), (record_index == '0) && (sample_index == '0) && (value == '0))
  `BER_ASSERT_NOW(a_open_zero, out_valid && (action == ACT_OPEN), (sample_index == '0) && (value == '0))

endmodule

bind ber_record_deframer_top ber_chk u_ber_chk (.*);

>>> verif/tb.sv
// Testbench for ber_record_deframer_top: drives buffers of 32-bit words and checks each
// result against its directed row or an in-bench parser of the record framing. Needs ber_pkg and the top level.
`timescale 1ns / 1ps

module tb;
  import ber_pkg::*;

  localparam int N_DIR      = 19;
  localparam int N_RANDOM   = 431;
  localparam int WD_LIMIT   = 2000;
  localparam int DRAIN_CYC  = 8;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [WORD_W-1:0] w;
    logic              last;
    logic              fixed;
    action_t           act;
    logic [RIDX_W-1:0] rec;
    logic [SIDX_W-1:0] sidx;
    logic [WORD_W-1:0] val;
    status_t           st;
  } dir_row_t;

  typedef struct {
    logic [WORD_W-1:0] w;
    logic              last;
    bit                fixed;
    res_t              want;
  } buf_word_t;

  localparam dir_row_t DIR_TBL [N_DIR] = '{
    '{32'hFFFF_FFFF,   1'b0, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_NOSIG},
    '{32'h0000_0000,   1'b1, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_NOSIG},
    '{SIGNATURE_WORD,  1'b0, 1'b1, ACT_OPEN, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{SIGNATURE_WORD,  1'b0, 1'b1, ACT_OPEN, 2'd1, 6'd0, 32'h0,         ST_OK},
    '{32'hFFFF_FFFF,   1'b0, 1'b1, ACT_MODE, 2'd1, 6'd0, 32'hFFFF_FFFF, ST_OK},
    '{32'h0000_0000,   1'b0, 1'b1, ACT_TIME, 2'd1, 6'd0, 32'h0,         ST_OK},
    '{32'hA5A5_A5A5,   1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{SIGNATURE_WORD,  1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{32'h1234_5678,   1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{SIGNATURE_WORD,  1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{SIGNATURE_WORD,  1'b0, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_RECORDS},
    '{32'h5A5A_5A5A,   1'b0, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_RECORDS},
    '{32'h0000_0000,   1'b1, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_RECORDS},
    '{SIGNATURE_WORD,  1'b0, 1'b1, ACT_OPEN, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{32'h0000_0001,   1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{32'h8000_0000,   1'b0, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{SIGNATURE_WORD,  1'b1, 1'b0, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_OK},
    '{32'hDEAD_BEEF,   1'b1, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_NOSIG},
    '{32'h4245_5252,   1'b1, 1'b1, ACT_NONE, 2'd0, 6'd0, 32'h0,         ST_NOSIG}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [WORD_W-1:0] word = '0;
  logic              last_word = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ACT_W-1:0]  action;
  logic [RIDX_W-1:0] record_index;
  logic [SIDX_W-1:0] sample_index;
  logic [WORD_W-1:0] value;
  logic [STAT_W-1:0] status;
  logic              done_res;

  buf_word_t word_q[$];
  res_t      pending_res[$];
  int        send_idx = 0;
  int        burst_left = 0;
  int        gap_left = 0;
  int        rx_mode = 0;
  int        rx_left = 0;
  int        idle_cyc = 0;
  int        mismatch_cnt = 0;

  bit        rec_open = 1'b0;
  int        rec_cur = 0;
  bit        mode_next = 1'b0;
  int        samp_cnt = 0;
  status_t   err_code = ST_OK;

  ber_record_deframer_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .word         (word),
    .last_word    (last_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .record_index (record_index),
    .sample_index (sample_index),
    .value        (value),
    .status       (status),
    .done_res     (done_res)
  );

  always #2 clk = ~clk;

  task automatic deframe_word(input logic [WORD_W-1:0] w, input logic last, output res_t r);
    r = '0;
    r.action = ACT_NONE;
    if (err_code == ST_OK) begin
      if (w == SIGNATURE_WORD) begin
        if (rec_open && rec_cur + 1 >= RECORDS) begin
          err_code = ST_RECORDS;
        end else begin
          rec_cur = rec_open ? rec_cur + 1 : 0;
          rec_open = 1'b1;
          mode_next = 1'b1;
          samp_cnt = 0;
          r.action = ACT_OPEN;
          r.record_index = RIDX_W'(rec_cur);
        end
      end else if (!rec_open) begin
        err_code = ST_NOSIG;
      end else if (mode_next) begin
        mode_next = 1'b0;
        r.action = ACT_MODE;
        r.record_index = RIDX_W'(rec_cur);
        r.value = w;
      end else if (samp_cnt >= 2 * SAMPLES) begin
        err_code = ST_SAMPLES;
      end else begin
        r.record_index = RIDX_W'(rec_cur);
        r.value = w;
        if (samp_cnt < SAMPLES) begin
          r.action = ACT_TIME;
          r.sample_index = SIDX_W'(samp_cnt);
        end else begin
          r.action = ACT_ERR;
          r.sample_index = SIDX_W'(samp_cnt - SAMPLES);
        end
        samp_cnt++;
      end
    end
    r.status = err_code;
    r.done_res = last;
    if (last) begin
      rec_open = 1'b0;
      rec_cur = 0;
      mode_next = 1'b0;
      samp_cnt = 0;
      err_code = ST_OK;
    end
  endtask

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 39))
      0:       return '0;
      1:       return '1;
      2:       return SIGNATURE_WORD;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(input logic [WORD_W-1:0] w, input logic last);
    buf_word_t s;
    s.w = w;
    s.last = last;
    s.fixed = 1'b0;
    s.want = '0;
    word_q.push_back(s);
  endtask

  // Signature, usually a mode word, then n samples of random content.
  task automatic add_record(input int n);
    add_item(SIGNATURE_WORD, 1'b0);
    if ($urandom_range(0, 9) != 0) add_item(rand_word(), 1'b0);
    for (int i = 0; i < n; i++) add_item(rand_word(), 1'b0);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_cnt < MAX_PRINTS)
      $display("tb: mismatch on %s at %0t: got 0x%0h, want 0x%0h", what, $realtime, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result();
    res_t e;
    if (pending_res.size() == 0) begin
      report_mismatch("result with nothing pending, action", action, 0);
      return;
    end
    e = pending_res.pop_front();
    if (action !== e.action) report_mismatch("action", action, e.action);
    if (record_index !== e.record_index) report_mismatch("record_index", record_index, e.record_index);
    if (sample_index !== e.sample_index) report_mismatch("sample_index", sample_index, e.sample_index);
    if (value !== e.value) report_mismatch("value", value, e.value);
    if (status !== e.status) report_mismatch("status", status, e.status);
    if (done_res !== e.done_res) report_mismatch("done_res", done_res, e.done_res);
  endtask

  always @(posedge clk) begin : drive_input
    res_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        deframe_word(word_q[send_idx].w, word_q[send_idx].last, r);
        pending_res.push_back(word_q[send_idx].fixed ? word_q[send_idx].want : r);
        send_idx++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (send_idx < word_q.size()) begin
          in_valid <= 1'b1;
          word <= word_q[send_idx].w;
          last_word <= word_q[send_idx].last;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 200);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 1);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main_seq
    buf_word_t s;
    int n_rec;
    int pick;
    for (int i = 0; i < N_DIR; i++) begin
      s.w = DIR_TBL[i].w;
      s.last = DIR_TBL[i].last;
      s.fixed = DIR_TBL[i].fixed;
      s.want = '0;
      s.want.action = DIR_TBL[i].act;
      s.want.record_index = DIR_TBL[i].rec;
      s.want.sample_index = DIR_TBL[i].sidx;
      s.want.value = DIR_TBL[i].val;
      s.want.status = DIR_TBL[i].st;
      s.want.done_res = DIR_TBL[i].last;
      word_q.push_back(s);
    end
    // overrun one record past both sample halves
    add_record(2 * SAMPLES + 2);
    word_q[word_q.size() - 1].last = 1'b1;
    while (word_q.size() < N_DIR + N_RANDOM) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) add_item(rand_word(), 1'b0);
      end else begin
        n_rec = ($urandom_range(0, 4) == 0) ? $urandom_range(3, RECORDS + 1) : $urandom_range(1, 2);
        for (int i = 0; i < n_rec; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 87) add_record($urandom_range(0, 8));
          else if (pick < 97) add_record($urandom_range(SAMPLES - 4, SAMPLES + 4));
          else add_record($urandom_range(2 * SAMPLES - 8, 2 * SAMPLES + 4));
        end
      end
      word_q[word_q.size() - 1].last = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (send_idx < word_q.size()) @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
